>>> hw/rtl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and constants of the mixed-radix index counter.
// ----------------------------------------------------------------------------
package mrc_pkg;

  // Default shape of the counter
  localparam int NDIMS_DEF      = 4;
  localparam int DIGIT_BITS_DEF = 8;

  // Fixed field widths
  localparam int OPCODE_W    = 2;
  localparam int MASK_W      = 4;
  localparam int OUT_DIGIT_W = 8;
  localparam int INDEX_W     = 32;
  localparam int NUM_OUT_DIG = 4;

  // Configuration layout
  localparam int DIM_SIZE_W = 9;
  localparam int NSIZE_REGS = 4;
  localparam int SLOT_W     = 3;
  localparam int NUM_SLOTS  = 4;
  localparam int LIST_W     = SLOT_W * NUM_SLOTS;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  localparam logic [DIM_SIZE_W-1:0] DIM_SIZE_RST = DIM_SIZE_W'(256);
  localparam logic [LIST_W-1:0]     LIST_RST     = LIST_W'(1672);

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_DIM0  = 3'd0;
  localparam logic [2:0] REG_DIM1  = 3'd1;
  localparam logic [2:0] REG_DIM2  = 3'd2;
  localparam logic [2:0] REG_DIM3  = 3'd3;
  localparam logic [2:0] REG_CARRY = 3'd4;
  localparam logic [2:0] REG_KEEP  = 3'd5;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_STEP  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;

  // Configuration handed from the register file to the sequencer
  typedef struct packed {
    logic [NSIZE_REGS-1:0][DIM_SIZE_W-1:0] dim_size;
    logic [LIST_W-1:0]                     carry_order;
    logic [LIST_W-1:0]                     keep_order;
  } mrc_cfg_t;

endpackage

>>> hw/rtl/mrc_if.sv
// ----------------------------------------------------------------------------
// mrc_if
// Valid/ready channels: operation requests in, counter results out.
// ----------------------------------------------------------------------------
interface mrc_req_if import mrc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [MASK_W-1:0]   clear_mask;

  modport source (output valid, opcode, clear_mask, input ready);
  modport sink   (input valid, opcode, clear_mask, output ready);
endinterface

interface mrc_rsp_if import mrc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OUT_DIGIT_W-1:0] digit_0;
  logic [OUT_DIGIT_W-1:0] digit_1;
  logic [OUT_DIGIT_W-1:0] digit_2;
  logic [OUT_DIGIT_W-1:0] digit_3;
  logic [INDEX_W-1:0]     linear_index;
  logic                   wrapped;

  modport source (output valid, digit_0, digit_1, digit_2, digit_3, linear_index, wrapped,
                  input ready);
  modport sink   (input valid, digit_0, digit_1, digit_2, digit_3, linear_index, wrapped,
                  output ready);
endinterface

>>> hw/rtl/mrc_regs.sv
// ----------------------------------------------------------------------------
// mrc_regs
// APB-style configuration registers: digit radices, carry list, keep list.
// ----------------------------------------------------------------------------
module mrc_regs import mrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output mrc_cfg_t              cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSIZE_REGS; i++) begin
        cfg.dim_size[i] <= DIM_SIZE_RST;
      end
      cfg.carry_order <= LIST_RST;
      cfg.keep_order  <= LIST_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DIM0:  cfg.dim_size[0]  <= pwdata[DIM_SIZE_W-1:0];
        REG_DIM1:  cfg.dim_size[1]  <= pwdata[DIM_SIZE_W-1:0];
        REG_DIM2:  cfg.dim_size[2]  <= pwdata[DIM_SIZE_W-1:0];
        REG_DIM3:  cfg.dim_size[3]  <= pwdata[DIM_SIZE_W-1:0];
        REG_CARRY: cfg.carry_order  <= pwdata[LIST_W-1:0];
        REG_KEEP:  cfg.keep_order   <= pwdata[LIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data
  always_comb begin
    case (reg_idx)
      REG_DIM0:  prdata = APB_DATA_W'(cfg.dim_size[0]);
      REG_DIM1:  prdata = APB_DATA_W'(cfg.dim_size[1]);
      REG_DIM2:  prdata = APB_DATA_W'(cfg.dim_size[2]);
      REG_DIM3:  prdata = APB_DATA_W'(cfg.dim_size[3]);
      REG_CARRY: prdata = APB_DATA_W'(cfg.carry_order);
      REG_KEEP:  prdata = APB_DATA_W'(cfg.keep_order);
      default:   prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/mrc_mac.sv
// ----------------------------------------------------------------------------
// mrc_mac
// Shared multiply-add unit: p = a * b + c (mod 2^32), plus p < radix.
// Serves both the digit increment and the index accumulation.
// ----------------------------------------------------------------------------
module mrc_mac import mrc_pkg::*; #(
  parameter int DIGIT_BITS = DIGIT_BITS_DEF
) (
  input  logic [INDEX_W-1:0]    a,
  input  logic [DIGIT_BITS:0]   b,
  input  logic [INDEX_W-1:0]    c,
  input  logic [DIGIT_BITS:0]   radix,
  output logic [INDEX_W-1:0]    p,
  output logic                  lt
);

  localparam int PROD_W = INDEX_W + DIGIT_BITS + 1;

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(a) * PROD_W'(b);
  assign p    = prod[INDEX_W-1:0] + c;
  assign lt   = p < INDEX_W'(radix);

endmodule

>>> hw/rtl/mixed_radix_index_counter.sv
// ----------------------------------------------------------------------------
// mixed_radix_index_counter
// Sequencing: a step walks the carry list (one listed digit
//   per cycle), then does one index multiply-add per keep-list digit, then
//   loads the result register, which waits while the response slot is full;
//   read or clear skip the carry walk.
// Throughput: one item at a time; the next is taken the cycle after the
//   result register loads. Reset zeroes all digits and restores defaults.
// ----------------------------------------------------------------------------
module mixed_radix_index_counter import mrc_pkg::*; #(
  parameter int NDIMS      = NDIMS_DEF,
  parameter int DIGIT_BITS = DIGIT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  mrc_req_if.sink               req,
  mrc_rsp_if.source             rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int RW = DIGIT_BITS + 1;
  localparam int SW = (NDIMS > 1) ? $clog2(NDIMS) : 1;
  localparam int KW = $clog2(NDIMS + 1);
  localparam logic [SLOT_W:0] NDIMS_S = (SLOT_W + 1)'(NDIMS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_INDEX
  } state_t;

  state_t                 state;
  mrc_cfg_t               cfg;
  logic [DIGIT_BITS-1:0]  digits [NDIMS];
  logic [RW-1:0]          radix_eff [NDIMS];
  logic [SLOT_W-1:0]      carry_slot [NDIMS];
  logic [SLOT_W-1:0]      keep_slot [NDIMS];
  logic [NDIMS-1:0]       clr_vec;
  logic [OUT_DIGIT_W-1:0] out_dig [NUM_OUT_DIG];
  logic [KW-1:0]          k_q;
  logic [KW-1:0]          km1;
  logic [KW-1:0]          keep_len;
  logic [INDEX_W-1:0]     num_q;
  logic                   wrap_q;
  logic [SLOT_W-1:0]      cur_carry;
  logic                   carry_ok;
  logic [SW-1:0]          rd_sel;
  logic [DIGIT_BITS-1:0]  rd_digit;
  logic [RW-1:0]          rd_radix;
  logic [INDEX_W-1:0]     mac_a;
  logic [RW-1:0]          mac_b;
  logic [INDEX_W-1:0]     mac_c;
  logic [INDEX_W-1:0]     mac_p;
  logic                   mac_lt;
  logic                   rsp_load;

  function automatic logic [RW-1:0] clamp_radix(logic [DIM_SIZE_W-1:0] r);
    logic [INDEX_W-1:0] r32;
    logic [INDEX_W-1:0] max32;
    r32   = INDEX_W'(r);
    max32 = INDEX_W'(1) << DIGIT_BITS;
    if (r32 == '0) begin
      r32 = INDEX_W'(1);
    end else if (r32 > max32) begin
      r32 = max32;
    end
    return r32[RW-1:0];
  endfunction

  // Configuration registers
  mrc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Per-digit radix, list slots and clear bits (slots past the register read 0)
  for (genvar g = 0; g < NDIMS; g++) begin : g_dim
    if (g < NSIZE_REGS) begin : g_reg
      assign radix_eff[g] = clamp_radix(cfg.dim_size[g]);
      assign clr_vec[g]   = req.clear_mask[g];
    end else begin : g_fix
      assign radix_eff[g] = clamp_radix(DIM_SIZE_RST);
      assign clr_vec[g]   = 1'b0;
    end
    if (g < NUM_SLOTS) begin : g_slot
      assign carry_slot[g] = cfg.carry_order[g*SLOT_W +: SLOT_W];
      assign keep_slot[g]  = cfg.keep_order[g*SLOT_W +: SLOT_W];
    end else begin : g_noslot
      assign carry_slot[g] = '0;
      assign keep_slot[g]  = '0;
    end
  end

  // Length of the keep list: leading slots that name a digit
  always_comb begin
    logic stop;
    stop     = 1'b0;
    keep_len = '0;
    for (int i = 0; i < NDIMS; i++) begin
      if (!stop && ({1'b0, keep_slot[i]} < NDIMS_S)) begin
        keep_len = keep_len + KW'(1);
      end else begin
        stop = 1'b1;
      end
    end
  end

  // Digit select for the shared unit
  assign km1       = k_q - KW'(1);
  assign cur_carry = carry_slot[k_q[SW-1:0]];
  assign carry_ok  = {1'b0, cur_carry} < NDIMS_S;

  always_comb begin
    if (state == S_STEP) begin
      rd_sel = cur_carry[SW-1:0];
    end else begin
      rd_sel = keep_slot[km1[SW-1:0]][SW-1:0];
    end
  end

  assign rd_digit = digits[rd_sel];
  assign rd_radix = radix_eff[rd_sel];

  // Operand mux: increment during the carry walk, Horner step for the index
  always_comb begin
    if (state == S_STEP) begin
      mac_a = INDEX_W'(rd_digit);
      mac_b = RW'(1);
      mac_c = INDEX_W'(1);
    end else begin
      mac_a = num_q;
      mac_b = rd_radix;
      mac_c = INDEX_W'(rd_digit);
    end
  end

  mrc_mac #(
    .DIGIT_BITS (DIGIT_BITS)
  ) u_mac (
    .a     (mac_a),
    .b     (mac_b),
    .c     (mac_c),
    .radix (rd_radix),
    .p     (mac_p),
    .lt    (mac_lt)
  );

  // Result digit fields
  for (genvar g = 0; g < NUM_OUT_DIG; g++) begin : g_out
    if (g < NDIMS) begin : g_live
      assign out_dig[g] = OUT_DIGIT_W'(digits[g]);
    end else begin : g_zero
      assign out_dig[g] = '0;
    end
  end

  assign req.ready = (state == S_IDLE);

  // Result register loads once the index is done and the slot is free
  assign rsp_load = (state == S_INDEX) && (k_q == '0) && (!rsp.valid || rsp.ready);

  // Sequencer, digit store and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      k_q       <= '0;
      num_q     <= '0;
      wrap_q    <= 1'b0;
      for (int i = 0; i < NDIMS; i++) begin
        digits[i] <= '0;
      end
    end else begin
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            wrap_q <= 1'b0;
            if (req.opcode == OP_STEP) begin
              k_q   <= '0;
              state <= S_STEP;
            end else begin
              if (req.opcode == OP_CLEAR) begin
                for (int i = 0; i < NDIMS; i++) begin
                  if (clr_vec[i]) begin
                    digits[i] <= '0;
                  end
                end
              end
              k_q   <= keep_len;
              num_q <= '0;
              state <= S_INDEX;
            end
          end
        end
        S_STEP: begin
          if (!carry_ok) begin
            // list ended: carry left the last listed digit unless list empty
            wrap_q <= (k_q != '0);
            k_q    <= keep_len;
            num_q  <= '0;
            state  <= S_INDEX;
          end else if (mac_lt) begin
            digits[rd_sel] <= mac_p[DIGIT_BITS-1:0];
            k_q            <= keep_len;
            num_q          <= '0;
            state          <= S_INDEX;
          end else begin
            digits[rd_sel] <= '0;
            if (k_q == KW'(NDIMS - 1)) begin
              wrap_q <= 1'b1;
              k_q    <= keep_len;
              num_q  <= '0;
              state  <= S_INDEX;
            end else begin
              k_q <= k_q + KW'(1);
            end
          end
        end
        S_INDEX: begin
          if (k_q == '0) begin
            if (rsp_load) begin
              rsp.digit_0      <= out_dig[0];
              rsp.digit_1      <= out_dig[1];
              rsp.digit_2      <= out_dig[2];
              rsp.digit_3      <= out_dig[3];
              rsp.linear_index <= num_q;
              rsp.wrapped      <= wrap_q;
              state            <= S_IDLE;
            end
          end else begin
            num_q <= mac_p;
            k_q   <= km1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
